// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pctdec_pkg.sv
`default_nettype none

package pctdec_pkg;

  localparam int CAP_W   = 13;
  localparam int CNT_W   = 13;
  localparam int QDEPTH  = 4;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_TERM  = 8'h00;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_PCT,
    PEND_DIGIT
  } pend_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_char;
    logic       done;
    logic       status;
  } res_t;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c inside {[CH_0:CH_9]}) || (c inside {[CH_UA:CH_UF]}) ||
             (c inside {[CH_LA:CH_LF]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[CH_0:CH_9]}) begin
      d = c - CH_0;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d = c - CH_UA + 8'(HEX_TEN);
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d = c - CH_LA + 8'(HEX_TEN);
    end
    hex_val = d[3:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/percent_decoder_core.sv
`default_nettype none

// Percent decoder: one source byte per word on the input channel, byte 0 ends
// a string. Each byte is decoded in the cycle it is accepted and its results
// (none, one, two or three words) go into a four-entry output queue. The
// input is taken whenever at most one result word is waiting, so with the
// output side draining, one byte is accepted every cycle. A byte that causes
// two or three results (a broken escape, or a terminator that flushes a held
// '%' and digit) holds the input off while the queue drains. Results are
// registered in the queue before they leave. The capacity register is
// written through the cfg channel, which is always ready; write it only
// between strings.
module percent_decoder_core
  import pctdec_pkg::*;
#(
  parameter int MAX_CAPACITY = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic [7:0]       in_byte,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [7:0]       out_byte,
  output      logic             is_char,
  output      logic             done_res,
  output      logic             status,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  localparam logic [16:0] MAX_CAP_W = 17'(MAX_CAPACITY);

  logic [CAP_W-1:0] out_capacity;
  pend_t            pending, pending_next;
  logic [7:0]       held, held_next;
  logic [CNT_W-1:0] chars_emitted, chars_emitted_next;
  logic             overflowed, overflowed_next;

  res_t             q [QDEPTH];
  res_t             q_next [QDEPTH];
  logic [2:0]       count, count_next;

  logic             accept, pop, term;
  logic [CAP_W-1:0] cap_eff;
  logic [7:0]       cand [3];
  logic [2:0]       want, keep;
  res_t             r [3];
  logic [1:0]       rn;
  logic [2:0]       nb, idx;
  logic [CNT_W-1:0] cnt;
  logic             ov;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count > 3'd1);
  assign out_valid = (count != 3'd0);
  assign out_byte  = q[0].data;
  assign is_char   = q[0].is_char;
  assign done_res  = q[0].done;
  assign status    = q[0].status;
  assign accept    = in_valid & ~in_stall;
  assign pop       = out_valid & ~out_stall;
  assign term      = (in_byte == CH_TERM);
  assign cap_eff   = ({4'b0, out_capacity} > MAX_CAP_W) ? MAX_CAP_W[CAP_W-1:0] : out_capacity;

  // decode and capacity check
  always_comb begin
    pending_next       = pending;
    held_next          = held;
    chars_emitted_next = chars_emitted;
    overflowed_next    = overflowed;
    want               = 3'b000;
    keep               = 3'b000;
    cand[0]            = CH_PCT;
    cand[1]            = held;
    cand[2]            = in_byte;
    for (int k = 0; k < 3; k++) begin
      r[k] = '0;
    end
    rn  = 2'd0;
    cnt = chars_emitted;
    ov  = overflowed;

    if (term) begin
      want[0] = (pending != PEND_NONE);
      want[1] = (pending == PEND_DIGIT);
    end else begin
      case (pending)
        PEND_NONE: begin
          if (in_byte == CH_PCT) begin
            pending_next = PEND_PCT;
          end else begin
            cand[0] = in_byte;
            want[0] = 1'b1;
          end
        end
        PEND_PCT: begin
          if (hex_ok(in_byte)) begin
            held_next    = in_byte;
            pending_next = PEND_DIGIT;
          end else begin
            want[0] = 1'b1;
            if (in_byte == CH_PCT) begin
              pending_next = PEND_PCT;
            end else begin
              cand[1]      = in_byte;
              want[1]      = 1'b1;
              pending_next = PEND_NONE;
            end
          end
        end
        PEND_DIGIT: begin
          held_next = 8'h00;
          if (hex_ok(in_byte)) begin
            cand[0]      = {hex_val(held), hex_val(in_byte)};
            want[0]      = 1'b1;
            pending_next = PEND_NONE;
          end else begin
            want[0] = 1'b1;
            want[1] = 1'b1;
            if (in_byte == CH_PCT) begin
              pending_next = PEND_PCT;
            end else begin
              want[2]      = 1'b1;
              pending_next = PEND_NONE;
            end
          end
        end
        default: begin
          pending_next = PEND_NONE;
        end
      endcase
    end

    for (int k = 0; k < 3; k++) begin
      if (want[k] && !ov) begin
        if (({1'b0, cnt} + 14'd1) >= {1'b0, cap_eff}) begin
          ov = 1'b1;
        end else begin
          cnt     = cnt + 1'b1;
          keep[k] = 1'b1;
        end
      end
    end

    for (int k = 0; k < 3; k++) begin
      if (keep[k]) begin
        r[rn] = '{data: cand[k], is_char: 1'b1, done: 1'b0, status: 1'b0};
        rn    = rn + 2'd1;
      end
    end

    if (term) begin
      if (out_capacity == '0) begin
        ov = 1'b1;
      end
      r[rn]              = '{data: 8'h00, is_char: 1'b0, done: 1'b1, status: ov};
      rn                 = rn + 2'd1;
      pending_next       = PEND_NONE;
      held_next          = 8'h00;
      chars_emitted_next = '0;
      overflowed_next    = 1'b0;
    end else begin
      chars_emitted_next = cnt;
      overflowed_next    = ov;
    end
  end

  // output queue
  always_comb begin
    nb = count - {2'b00, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      idx = 3'(i) - nb;
      if (accept && (3'(i) >= nb) && (idx < {1'b0, rn})) begin
        q_next[i] = r[idx[1:0]];
      end
    end
    count_next = nb + (accept ? {1'b0, rn} : 3'd0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
    if (rst) begin
      count         <= 3'd0;
      out_capacity  <= CAP_RESET;
      pending       <= PEND_NONE;
      held          <= 8'h00;
      chars_emitted <= '0;
      overflowed    <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        out_capacity <= cfg_data;
      end
      if (accept) begin
        pending       <= pending_next;
        held          <= held_next;
        chars_emitted <= chars_emitted_next;
        overflowed    <= overflowed_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pctdec_checker.sv
`default_nettype none

`include "assert_macros.svh"

module pctdec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_byte,
  input wire logic        is_char,
  input wire logic        done_res,
  input wire logic        status
);

  // stalled result word holds
  `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_char) && $stable(done_res) && $stable(status), "stalled output word changed")

  // end-of-string word carries no character
  `CHK_ASSERT(a_done_empty, out_valid && done_res |-> !is_char && (out_byte == 8'h00), "end word carries a character")

  // character words report ok status
  `CHK_ASSERT(a_char_status, out_valid && is_char |-> !status && !done_res, "character word with status or done")

  // queue empty and input open right after reset
  `CHK_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_stall, "queue not empty after reset")

  // an empty output queue never holds off the input
  `CHK_ASSERT(a_no_idle_stall, !out_valid |-> !in_stall, "input stalled with empty queue")

endmodule

bind percent_decoder_core pctdec_checker u_pctdec_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pctdec_pkg::*;

  localparam int CAP_MAX = 4096;
  localparam int SETTLE  = 4;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_byte;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte;
  logic             is_char;
  logic             done_res;
  logic             status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  percent_decoder_core #(
    .MAX_CAPACITY(CAP_MAX)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_char   (is_char),
    .done_res  (done_res),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // decoder state as the block should hold it
  pend_t            pend       = PEND_NONE;
  logic [7:0]       held_digit = 8'h00;
  int               chars_out  = 0;
  logic             cap_over   = 1'b0;
  logic [CAP_W-1:0] capacity   = CAP_RESET;

  res_t decoded_q[$];
  int   fail_count  = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   hold_cycles = 0;
  int   hold_len    = 0;
  int   hold_seq    = 0;
  int   hold_seen   = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + int'(HEX_TEN);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + int'(HEX_TEN);
    return -1;
  endfunction

  function automatic void emit(input logic [7:0] c);
    int lim;
    lim = (capacity > CAP_MAX) ? CAP_MAX : int'(capacity);
    if (cap_over) return;
    if (chars_out + 1 >= lim) begin
      cap_over = 1'b1;
      return;
    end
    chars_out++;
    decoded_q.push_back('{data: c, is_char: 1'b1, done: 1'b0, status: 1'b0});
  endfunction

  function automatic void scan_plain(input logic [7:0] b);
    if (b == CH_PCT) begin
      pend = PEND_PCT;
    end else begin
      emit(b);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    int lo;
    int hi;
    if (b == CH_TERM) begin
      if (pend != PEND_NONE) emit(CH_PCT);
      if (pend == PEND_DIGIT) emit(held_digit);
      if (capacity == '0) cap_over = 1'b1;
      decoded_q.push_back('{data: 8'h00, is_char: 1'b0, done: 1'b1, status: cap_over});
      pend = PEND_NONE;
      held_digit = 8'h00;
      chars_out = 0;
      cap_over = 1'b0;
      return;
    end
    case (pend)
      PEND_PCT: begin
        if (nibble_of(b) >= 0) begin
          held_digit = b;
          pend = PEND_DIGIT;
        end else begin
          pend = PEND_NONE;
          emit(CH_PCT);
          scan_plain(b);
        end
      end
      PEND_DIGIT: begin
        lo = nibble_of(b);
        pend = PEND_NONE;
        if (lo >= 0) begin
          hi = nibble_of(held_digit);
          emit(8'(hi * 16 + lo));
        end else begin
          emit(CH_PCT);
          emit(held_digit);
          scan_plain(b);
        end
        held_digit = 8'h00;
      end
      default: begin
        pend = PEND_NONE;
        scan_plain(b);
      end
    endcase
  endfunction

  function automatic void check_word();
    res_t want;
    res_t got;
    got = '{data: out_byte, is_char: is_char, done: done_res, status: status};
    if (decoded_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected word: data %h char %b done %b status %b",
                 got.data, got.is_char, got.done, got.status);
      return;
    end
    want = decoded_q.pop_front();
    if (got.data !== want.data || got.is_char !== want.is_char ||
        got.done !== want.done || got.status !== want.status) begin
      fail_count++;
      if (fail_count <= 10)
        $display("word mismatch at %0t: got %h/%b/%b/%b want %h/%b/%b/%b", $realtime,
                 got.data, got.is_char, got.done, got.status,
                 want.data, want.is_char, want.done, want.status);
    end
  endfunction

  // outputs checked first, then the accepted byte and config word are folded in
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_word();
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && !in_stall) decode_byte(in_byte);
    end
  end

  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_cycles = hold_len;
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #3600000;
    $display("FAIL percent_decoder_core");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic start_hold(input int n);
    @(posedge clk);
    hold_len = n;
    hold_seq++;
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v) - 8'(HEX_TEN);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (nibble_of(c) >= 0);
    return c;
  endfunction

  task automatic send_escape(inout int count);
    int kind;
    kind = $urandom_range(0, 99);
    send_byte(CH_PCT);
    count++;
    if (kind < 70) begin
      send_byte(hex_char());
      send_byte(hex_char());
      count += 2;
    end else if (kind < 80) begin
      send_byte(non_hex());
      count++;
    end else if (kind < 92) begin
      send_byte(hex_char());
      send_byte(non_hex());
      count += 2;
    end
  endtask

  task automatic send_random_string(inout int count);
    int len;
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 45) begin
        send_escape(count);
      end else begin
        send_byte(8'($urandom_range(1, 255)));
        count++;
      end
    end
    send_byte(CH_TERM);
    count++;
  endtask

  task automatic test_directed();
    send_byte(8'hFF);
    send_byte(8'h01);
    send_text("%41%fF%%41%G%4G%4");
    send_byte(CH_TERM);
    send_text("%");
    send_byte(CH_TERM);
    send_byte(CH_TERM);
  endtask

  task automatic test_capacity();
    logic [CAP_W-1:0] caps[7];
    caps = '{13'd1, 13'd2, 13'd4, 13'd5, 13'd0, 13'h1FFF, CAP_RESET};
    foreach (caps[i]) begin
      write_cap(caps[i]);
      send_text("%41b%4");
      send_byte(CH_TERM);
      send_byte(CH_TERM);
    end
  endtask

  task automatic test_pressure();
    idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    // output held off while input keeps coming, queue must fill
    start_hold(80);
    send_text("abc%4G%zz%41xy%%7e%0");
    send_byte(CH_TERM);
    wait_drained();
    // held escape survives a full drain
    send_text("%4");
    wait_drained();
    send_text("1");
    send_byte(CH_TERM);
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int cap);
    int count;
    count = 0;
    write_cap(CAP_W'(cap));
    idle_pct = idle;
    stall_pct = stall;
    while (count < 10) send_random_string(count);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_capacity();
    test_pressure();
    test_random_phase(0, 0, $urandom_range(2, 9));
    test_random_phase(79, 0, $urandom_range(1, 20));
    test_random_phase(0, 79, $urandom_range(3, 12));
    test_random_phase(21, 21, CAP_MAX);

    wait_drained();
    if (decoded_q.size() != 0) begin
      fail_count += decoded_q.size();
      $display("%0d words never arrived", decoded_q.size());
    end
    if (fail_count == 0) begin
      $display("PASS percent_decoder_core");
    end else begin
      $display("FAIL percent_decoder_core");
    end
    $finish;
  end

endmodule
